FILE: src/m52_pkg.sv
// ============================================================================
// m52_pkg
// Shared types, widths and exponential tables for the Matern 5/2 block.
// ============================================================================
package m52_pkg;

    localparam int unsigned NUM_FIELDS = 4;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned WEIGHT_W   = 16;
    localparam int unsigned SUM_W      = 52;
    localparam int unsigned Q_W        = 55;
    localparam int unsigned Q_LOW_W    = 32;
    localparam int unsigned ROOT_W     = 28;
    localparam int unsigned ROOT_STEPS = 27;
    localparam int unsigned REM_W      = 56;
    localparam int unsigned P16_W      = 23;
    localparam int unsigned CORR_W     = 16;
    localparam int unsigned IDX_W      = 2;

    localparam logic [IDX_W-1:0] REG_WEIGHT0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_WEIGHT1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_WEIGHT2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_WEIGHT3 = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic [REM_W-1:0]          rem_t;
    typedef logic [ROOT_W+25:0]        res_t;

    typedef struct packed {
        logic               valid;
        logic [Q_LOW_W-1:0] q;
        rem_t               rem;
        res_t               res;
    } root_cell_t;

    function automatic logic [32:0] intp_lookup(input logic [3:0] n);
        logic [32:0] v;
        begin
            case (n)
                4'd0:    v = 33'd4294967296;
                4'd1:    v = 33'd1580030169;
                4'd2:    v = 33'd581260616;
                4'd3:    v = 33'd213833830;
                4'd4:    v = 33'd78665070;
                4'd5:    v = 33'd28939260;
                4'd6:    v = 33'd10646159;
                4'd7:    v = 33'd3916503;
                4'd8:    v = 33'd1440801;
                4'd9:    v = 33'd530041;
                4'd10:   v = 33'd194991;
                4'd11:   v = 33'd71733;
                4'd12:   v = 33'd26389;
                4'd13:   v = 33'd9708;
                4'd14:   v = 33'd3571;
                default: v = 33'd1314;
            endcase
            return v;
        end
    endfunction

    function automatic logic [16:0] frac_lookup(input logic [5:0] j);
        logic [16:0] v;
        begin
            case (j)
                6'd0:  v = 17'd65536; 6'd1:  v = 17'd63520; 6'd2:  v = 17'd61565;
                6'd3:  v = 17'd59671; 6'd4:  v = 17'd57835; 6'd5:  v = 17'd56056;
                6'd6:  v = 17'd54331; 6'd7:  v = 17'd52660; 6'd8:  v = 17'd51039;
                6'd9:  v = 17'd49469; 6'd10: v = 17'd47947; 6'd11: v = 17'd46472;
                6'd12: v = 17'd45042; 6'd13: v = 17'd43656; 6'd14: v = 17'd42313;
                6'd15: v = 17'd41011; 6'd16: v = 17'd39750; 6'd17: v = 17'd38527;
                6'd18: v = 17'd37341; 6'd19: v = 17'd36192; 6'd20: v = 17'd35079;
                6'd21: v = 17'd34000; 6'd22: v = 17'd32954; 6'd23: v = 17'd31940;
                6'd24: v = 17'd30957; 6'd25: v = 17'd30005; 6'd26: v = 17'd29081;
                6'd27: v = 17'd28187; 6'd28: v = 17'd27319; 6'd29: v = 17'd26479;
                6'd30: v = 17'd25664; 6'd31: v = 17'd24875;
                default: v = 17'd24109;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/matern52_correlation.sv
// ============================================================================
// matern52_correlation
// Matern 5/2 correlation of a point pair, one pair accepted per cycle.
// ============================================================================
// channel  | handshake            | payload
// -------- | -------------------- | ------------------------------------
// input    | start, busy          | a_coord0..3, b_coord0..3
// result   | done (one cycle)     | correlation
// config   | cfg_we               | cfg_index, cfg_data
// An item enters every cycle; busy is tied low. The result strobes once start
// has passed 3 distance stages, 27 square-root cells and 5 output stages.
// The row of root cells sets the latency. Reset clears valid flags and loads
// all weights with 1.0. No backpressure on the result side.
// ============================================================================
module matern52_correlation
#(
    parameter int unsigned DIMS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  m52_pkg::coord_t          a_coord0,
    input  m52_pkg::coord_t          a_coord1,
    input  m52_pkg::coord_t          a_coord2,
    input  m52_pkg::coord_t          a_coord3,
    input  m52_pkg::coord_t          b_coord0,
    input  m52_pkg::coord_t          b_coord1,
    input  m52_pkg::coord_t          b_coord2,
    input  m52_pkg::coord_t          b_coord3,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    output logic                     done,
    output logic [15:0]              correlation
);
    import m52_pkg::*;

    weight_t weight_reg [NUM_FIELDS];
    coord_t  a_in [NUM_FIELDS];
    coord_t  b_in [NUM_FIELDS];

    assign busy = 1'b0;
    assign a_in[0] = a_coord0; assign a_in[1] = a_coord1;
    assign a_in[2] = a_coord2; assign a_in[3] = a_coord3;
    assign b_in[0] = b_coord0; assign b_in[1] = b_coord1;
    assign b_in[2] = b_coord2; assign b_in[3] = b_coord3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
                weight_reg[k] <= weight_t'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WEIGHT0: weight_reg[0] <= cfg_data;
                REG_WEIGHT1: weight_reg[1] <= cfg_data;
                REG_WEIGHT2: weight_reg[2] <= cfg_data;
                REG_WEIGHT3: weight_reg[3] <= cfg_data;
                default:     weight_reg[0] <= weight_reg[0];
            endcase
        end
    end

    // distance: stage 1 absolute difference, stage 2 square, stage 3 weight, sum and times 5
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [16:0] ad_reg  [NUM_FIELDS];
    logic [33:0] sq_reg  [NUM_FIELDS];
    weight_t     w2_reg  [NUM_FIELDS];
    logic [Q_W-1:0] q_reg;
    logic [Q_W-1:0] q_next;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_FIELDS; k++)
            if (k < DIMS)
                sum_next = sum_next + SUM_W'(sq_reg[k]) * SUM_W'(w2_reg[k]);
        q_next = Q_W'(sum_next) * Q_W'(5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            logic signed [16:0] d;
            d = 17'(a_in[k]) - 17'(b_in[k]);
            ad_reg[k] <= d[16] ? 17'(-d) : 17'(d);
            sq_reg[k] <= 34'(ad_reg[k]) * 34'(ad_reg[k]);
            w2_reg[k] <= weight_reg[k];
        end
        q_reg <= q_next;
    end

    // square root: a row of cells
    root_cell_t chain [ROOT_STEPS+1];

    assign chain[0].valid = s3_valid_reg;
    assign chain[0].q     = q_reg[Q_LOW_W-1:0];
    assign chain[0].rem   = rem_t'(q_reg);
    assign chain[0].res   = '0;

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_root
        m52_root_cell #(.STEP(g)) u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // output stages
    root_cell_t rt;
    logic [ROOT_W-1:0] r;
    assign rt = chain[ROOT_STEPS];
    assign r  = rt.res[ROOT_W-1:0];

    // stage A: table reads
    logic           a_valid_reg, a_zero_reg;
    logic [ROOT_W-1:0] a_r_reg;
    logic [Q_LOW_W-1:0] a_q_reg;
    logic [16:0]    a_fj_reg, a_fj1_reg;
    logic [6:0]     a_w_reg;
    logic [32:0]    a_ip_reg;
    // stage B
    logic           b_valid_reg, b_zero_reg;
    logic [P16_W-1:0] b_p16_reg;
    logic [16:0]    b_f_reg;
    logic [32:0]    b_ip_reg;
    logic [31:0]    b_third;
    // stage C
    logic           c_valid_reg, c_zero_reg;
    logic [P16_W-1:0] c_p16_reg;
    logic [33:0]    c_e_reg;
    // stage D
    logic           d_valid_reg, d_zero_reg;
    logic [56:0]    d_prod_reg;
    // stage E
    logic           e_valid_reg;
    logic [15:0]    e_corr_reg;

    logic [5:0] jidx;
    assign jidx = {1'b0, r[11:7]};

    // q < 2^32 whenever r < 16: floor(q/3) by reciprocal multiply
    logic [63:0] third_prod;
    always_comb
    begin
        third_prod = 64'(a_q_reg) * 64'(32'hAAAAAAAB);
        b_third    = {1'b0, third_prod[63:33]};
    end

    logic [P16_W+8:0] p24;
    assign p24 = (P16_W+9)'(1 << 24) + ((P16_W+9)'(a_r_reg) << 12) + (P16_W+9)'(b_third)
               + (P16_W+9)'(128);

    logic [31:0] f_sum;
    assign f_sum = 32'(a_fj_reg) * 32'(8'd128 - {1'b0, a_w_reg})
                 + 32'(a_fj1_reg) * 32'(a_w_reg) + 32'd64;

    logic [49:0] e_full;
    assign e_full = 50'(b_ip_reg) * 50'(b_f_reg) + 50'd32768;

    logic [56:0] prod_r;
    assign prod_r = (d_prod_reg + (57'(1) << 32)) >> 33;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= rt.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_zero_reg <= (r >= ROOT_W'(65536));
        a_r_reg    <= r;
        a_q_reg    <= rt.q;
        a_fj_reg   <= frac_lookup(jidx);
        a_fj1_reg  <= frac_lookup(jidx + 6'd1);
        a_w_reg    <= r[6:0];
        a_ip_reg   <= intp_lookup(r[15:12]);

        b_zero_reg <= a_zero_reg;
        b_p16_reg  <= P16_W'(p24 >> 8);
        b_f_reg    <= 17'(f_sum >> 7);
        b_ip_reg   <= a_ip_reg;

        c_zero_reg <= b_zero_reg;
        c_p16_reg  <= b_p16_reg;
        c_e_reg    <= 34'(e_full >> 16);

        d_zero_reg <= c_zero_reg;
        d_prod_reg <= 57'(c_p16_reg) * 57'(c_e_reg);

        if (d_zero_reg)
            e_corr_reg <= 16'd0;
        else if (prod_r > 57'd32768)
            e_corr_reg <= 16'd32768;
        else
            e_corr_reg <= prod_r[15:0];
    end

    assign done        = e_valid_reg;
    assign correlation = e_corr_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##35 done)
        else $error("result strobe missing");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> correlation <= 16'd32768)
        else $error("correlation above one");
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
`endif

endmodule

FILE: src/m52_root_cell.sv
// ============================================================================
// m52_root_cell
// One step of the bitwise square root; registers the partial root each cycle.
// ============================================================================
module m52_root_cell
#(
    parameter int unsigned STEP = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  m52_pkg::root_cell_t cell_in,
    output m52_pkg::root_cell_t cell_out
);
    import m52_pkg::*;

    localparam int unsigned BIT_POS = 52 - 2 * STEP;

    res_t       bit_val;
    res_t       trial;
    root_cell_t cell_next;
    root_cell_t cell_reg;

    assign bit_val = res_t'(1) << BIT_POS;
    assign trial   = cell_in.res + bit_val;

    always_comb
    begin
        cell_next       = cell_in;
        if (cell_in.rem >= rem_t'(trial))
        begin
            cell_next.rem = cell_in.rem - rem_t'(trial);
            cell_next.res = (cell_in.res >> 1) + bit_val;
        end
        else
        begin
            cell_next.res = cell_in.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
